@@ src/rrot_pkg.sv @@
// shared widths, register codes and fixed-point cosine table helpers for the outline tessellator
package rrot_pkg;

  localparam int MAX_SEGMENTS_DEF   = 15;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int MIN_SEGMENTS       = 2;

  localparam int POS_W      = 16;
  localparam int SIZE_W     = 15;
  localparam int VERT_W     = 17;
  localparam int CTR_W      = POS_W + 2;
  localparam int RADIUS_W   = 12;
  localparam int SEG_CFG_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [SEG_CFG_W-1:0] ARC_SEGMENTS_RESET = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARC_SEGMENTS        = 3'd0,
    REG_RADIUS_TOP_LEFT     = 3'd1,
    REG_RADIUS_TOP_RIGHT    = 3'd2,
    REG_RADIUS_BOTTOM_RIGHT = 3'd3,
    REG_RADIUS_BOTTOM_LEFT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_t;

  localparam logic [63:0] Q60_ONE     = 64'h1000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1847;

  // (a*b) >> 60, truncating
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    al  = {32'd0, a[31:0]};
    ah  = {32'd0, a[63:32]};
    bl  = {32'd0, b[31:0]};
    bh  = {32'd0, b[63:32]};
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
    lo  = (mid << 32) | {32'd0, ll[31:0]};
    hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 4) | (lo >> 60);
  endfunction

  // (pi/2)*k/n in q60
  function automatic logic [63:0] angle_q60(input logic [63:0] k, input int n);
    logic [63:0] x;
    case (n)
      2:  x = (HALF_PI_Q60 / 64'd2)  * k + ((HALF_PI_Q60 % 64'd2)  * k) / 64'd2;
      3:  x = (HALF_PI_Q60 / 64'd3)  * k + ((HALF_PI_Q60 % 64'd3)  * k) / 64'd3;
      4:  x = (HALF_PI_Q60 / 64'd4)  * k + ((HALF_PI_Q60 % 64'd4)  * k) / 64'd4;
      5:  x = (HALF_PI_Q60 / 64'd5)  * k + ((HALF_PI_Q60 % 64'd5)  * k) / 64'd5;
      6:  x = (HALF_PI_Q60 / 64'd6)  * k + ((HALF_PI_Q60 % 64'd6)  * k) / 64'd6;
      7:  x = (HALF_PI_Q60 / 64'd7)  * k + ((HALF_PI_Q60 % 64'd7)  * k) / 64'd7;
      8:  x = (HALF_PI_Q60 / 64'd8)  * k + ((HALF_PI_Q60 % 64'd8)  * k) / 64'd8;
      9:  x = (HALF_PI_Q60 / 64'd9)  * k + ((HALF_PI_Q60 % 64'd9)  * k) / 64'd9;
      10: x = (HALF_PI_Q60 / 64'd10) * k + ((HALF_PI_Q60 % 64'd10) * k) / 64'd10;
      11: x = (HALF_PI_Q60 / 64'd11) * k + ((HALF_PI_Q60 % 64'd11) * k) / 64'd11;
      12: x = (HALF_PI_Q60 / 64'd12) * k + ((HALF_PI_Q60 % 64'd12) * k) / 64'd12;
      13: x = (HALF_PI_Q60 / 64'd13) * k + ((HALF_PI_Q60 % 64'd13) * k) / 64'd13;
      14: x = (HALF_PI_Q60 / 64'd14) * k + ((HALF_PI_Q60 % 64'd14) * k) / 64'd14;
      15: x = (HALF_PI_Q60 / 64'd15) * k + ((HALF_PI_Q60 % 64'd15) * k) / 64'd15;
      default: x = 64'd0;
    endcase
    return x;
  endfunction

  // cos((pi/2)*k/n) in q60 from a taylor series, elaboration only
  function automatic logic [63:0] cos_q60(input int k, input int n);
    logic [63:0] x, x2, sum, term;
    if (k == 0) return Q60_ONE;
    if (k >= n) return 64'd0;
    x    = angle_q60(64'(k), n);
    x2   = mul_q60(x, x);
    sum  = Q60_ONE;
    term = Q60_ONE;
    term = mul_q60(term, x2) / 64'd2;   sum = sum - term;
    term = mul_q60(term, x2) / 64'd12;  sum = sum + term;
    term = mul_q60(term, x2) / 64'd30;  sum = sum - term;
    term = mul_q60(term, x2) / 64'd56;  sum = sum + term;
    term = mul_q60(term, x2) / 64'd90;  sum = sum - term;
    term = mul_q60(term, x2) / 64'd132; sum = sum + term;
    term = mul_q60(term, x2) / 64'd182; sum = sum - term;
    term = mul_q60(term, x2) / 64'd240; sum = sum + term;
    term = mul_q60(term, x2) / 64'd306; sum = sum - term;
    term = mul_q60(term, x2) / 64'd380; sum = sum + term;
    term = mul_q60(term, x2) / 64'd462; sum = sum - term;
    term = mul_q60(term, x2) / 64'd552; sum = sum + term;
    term = mul_q60(term, x2) / 64'd650; sum = sum - term;
    if (sum[63]) return 64'd0;
    if (sum > Q60_ONE) return Q60_ONE;
    return sum;
  endfunction

  // round(2^fb * cos), half up
  function automatic logic [63:0] trig_value(input int k, input int n, input int fb);
    logic [63:0] c;
    c = cos_q60(k, n);
    return (c + (64'd1 << (59 - fb))) >> (60 - fb);
  endfunction

endpackage

@@ src/rrot_rect_if.sv @@
// rectangle input channel
interface rrot_rect_if;
  import rrot_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic        [SIZE_W-1:0] width;
  logic        [SIZE_W-1:0] height;

  modport source (output valid, output pos_x, output pos_y, output width, output height,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input width, input height,
                output ready);
endinterface

@@ src/rrot_vert_if.sv @@
// vertex output channel
interface rrot_vert_if;
  import rrot_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VERT_W-1:0] vert_x;
  logic signed [VERT_W-1:0] vert_y;
  logic [1:0]               corner_index;
  logic                     last_vertex;

  modport source (output valid, output vert_x, output vert_y, output corner_index,
                  output last_vertex, input ready);
  modport sink (input valid, input vert_x, input vert_y, input corner_index,
                input last_vertex, output ready);
endinterface

@@ src/rrot_cfg_if.sv @@
// configuration write channel
interface rrot_cfg_if;
  import rrot_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/rounded_rect_outline_tessellator_core.sv @@
// rounded rectangle outline tessellator: sequencer plus four-stage vertex pipeline
//
//   channel | dir | handshake     | item
//   --------+-----+---------------+---------------------------------------------
//   rect    | in  | valid / ready | pos_x, pos_y, width, height
//   vert    | out | valid / ready | vert_x, vert_y, corner_index, last_vertex
//   cfg     | in  | valid / ready | index, data (ready always high)
//
// one rectangle gives 4*(S+1) vertices, S = arc_segments clamped to 2..MAX_SEGMENTS
// the sequencer issues one vertex a cycle while vert is not stalled; after a rectangle is taken
// its vertices pass through stages 1, 2, 3 and 4 in order, and stage 4 drives vert
// a new rectangle is taken once the sequencer has issued the last vertex of the previous one
// reset is synchronous and clears the valid bits, the sequencer and the configuration registers
// a stall on vert freezes all stages together; nothing is dropped or repeated
module rounded_rect_outline_tessellator_core #(
  parameter int MAX_SEGMENTS   = rrot_pkg::MAX_SEGMENTS_DEF,
  parameter int TRIG_FRAC_BITS = rrot_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rrot_cfg_if.sink    cfg,
  rrot_rect_if.sink   rect,
  rrot_vert_if.source vert
);
  import rrot_pkg::*;

  localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int TAB_N  = 2 ** (2 * SEG_W);
  localparam int TW     = TRIG_FRAC_BITS + 1;
  localparam int PROD_W = RADIUS_W + TW;
  localparam int OFF_W  = RADIUS_W + 1;

  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (TRIG_FRAC_BITS - 1);

  typedef logic [TW-1:0] trig_tab_t [TAB_N];

  // entry {n, k} holds round(2^frac * cos((pi/2)*k/n)) for n >= MIN_SEGMENTS and k <= n, else zero
  function automatic trig_tab_t build_trig_tab();
    trig_tab_t   t;
    logic [63:0] v;
    int          n;
    int          k;
    for (int idx = 0; idx < TAB_N; idx++) begin
      n = idx >> SEG_W;
      k = idx & ((2 ** SEG_W) - 1);
      if (n >= MIN_SEGMENTS && k <= n) begin
        v = trig_value(k, n, TRIG_FRAC_BITS);
      end else begin
        v = 64'd0;
      end
      t[idx] = v[TW-1:0];
    end
    return t;
  endfunction

  localparam trig_tab_t TRIG_TAB = build_trig_tab();

  // configuration registers
  logic [SEG_CFG_W-1:0] seg_cfg;
  logic [RADIUS_W-1:0]  radius [4];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_cfg <= ARC_SEGMENTS_RESET;
      for (int c = 0; c < 4; c++) begin
        radius[c] <= '0;
      end
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_ARC_SEGMENTS:        seg_cfg   <= cfg.data[SEG_CFG_W-1:0];
        REG_RADIUS_TOP_LEFT:     radius[0] <= cfg.data[RADIUS_W-1:0];
        REG_RADIUS_TOP_RIGHT:    radius[1] <= cfg.data[RADIUS_W-1:0];
        REG_RADIUS_BOTTOM_RIGHT: radius[2] <= cfg.data[RADIUS_W-1:0];
        REG_RADIUS_BOTTOM_LEFT:  radius[3] <= cfg.data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SEG_CFG_W-1:0] seg_clamped;
  logic [SEG_W-1:0]     seg_eff;

  always_comb begin
    if (seg_cfg < SEG_CFG_W'(MIN_SEGMENTS)) begin
      seg_clamped = SEG_CFG_W'(MIN_SEGMENTS);
    end else if (seg_cfg > SEG_CFG_W'(MAX_SEGMENTS)) begin
      seg_clamped = SEG_CFG_W'(MAX_SEGMENTS);
    end else begin
      seg_clamped = seg_cfg;
    end
  end

  assign seg_eff = seg_clamped[SEG_W-1:0];

  // sequencer
  logic                     busy;
  corner_t                  gen_corner;
  logic [SEG_W-1:0]         gen_step;
  logic signed [POS_W-1:0]  rx;
  logic signed [POS_W-1:0]  ry;
  logic [SIZE_W-1:0]        rw;
  logic [SIZE_W-1:0]        rh;

  logic advance;
  logic issue;
  logic rect_take;
  logic step_last;
  logic s4_valid;

  assign advance   = !s4_valid || vert.ready;
  assign issue     = busy && advance;
  assign rect.ready = !busy;
  assign rect_take = rect.valid && !busy;
  assign step_last = (gen_step == seg_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      gen_corner <= CORNER_TL;
      gen_step   <= '0;
    end else if (rect_take) begin
      busy       <= 1'b1;
      gen_corner <= CORNER_TL;
      gen_step   <= '0;
    end else if (issue) begin
      if (step_last) begin
        gen_step   <= '0;
        gen_corner <= corner_t'(gen_corner + 2'd1);
        if (gen_corner == CORNER_BL) begin
          busy <= 1'b0;
        end
      end else begin
        gen_step <= gen_step + SEG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rect_take) begin
      rx <= rect.pos_x;
      ry <= rect.pos_y;
      rw <= rect.width;
      rh <= rect.height;
    end
  end

  // stage 1: table lookup and arc center
  logic                s1_valid;
  corner_t             s1_corner;
  logic                s1_last;
  logic [RADIUS_W-1:0] s1_rad;
  logic [TW-1:0]       s1_cos;
  logic [TW-1:0]       s1_sin;
  logic [CTR_W-1:0]    s1_cx;
  logic [CTR_W-1:0]    s1_cy;

  logic [RADIUS_W-1:0] rad_sel;
  logic [CTR_W-1:0]    px_ext;
  logic [CTR_W-1:0]    py_ext;
  logic [CTR_W-1:0]    w_ext;
  logic [CTR_W-1:0]    h_ext;
  logic [CTR_W-1:0]    r_ext;
  logic [CTR_W-1:0]    cx_next;
  logic [CTR_W-1:0]    cy_next;

  always_comb begin
    rad_sel = radius[gen_corner];
    px_ext  = {{(CTR_W - POS_W){rx[POS_W-1]}}, rx};
    py_ext  = {{(CTR_W - POS_W){ry[POS_W-1]}}, ry};
    w_ext   = {{(CTR_W - SIZE_W){1'b0}}, rw};
    h_ext   = {{(CTR_W - SIZE_W){1'b0}}, rh};
    r_ext   = {{(CTR_W - RADIUS_W){1'b0}}, rad_sel};
    case (gen_corner)
      CORNER_TL: begin
        cx_next = px_ext + r_ext;
        cy_next = py_ext + r_ext;
      end
      CORNER_TR: begin
        cx_next = px_ext + w_ext - r_ext;
        cy_next = py_ext + r_ext;
      end
      CORNER_BR: begin
        cx_next = px_ext + w_ext - r_ext;
        cy_next = py_ext + h_ext - r_ext;
      end
      default: begin
        cx_next = px_ext + r_ext;
        cy_next = py_ext + h_ext - r_ext;
      end
    endcase
  end

  // stage 2: radius times cosine and sine
  logic                s2_valid;
  corner_t             s2_corner;
  logic                s2_last;
  logic [PROD_W-1:0]   s2_pc;
  logic [PROD_W-1:0]   s2_ps;
  logic [CTR_W-1:0]    s2_cx;
  logic [CTR_W-1:0]    s2_cy;

  // stage 3: rounded, signed offsets
  logic                s3_valid;
  corner_t             s3_corner;
  logic                s3_last;
  logic [OFF_W-1:0]    s3_dx;
  logic [OFF_W-1:0]    s3_dy;
  logic [CTR_W-1:0]    s3_cx;
  logic [CTR_W-1:0]    s3_cy;

  logic [PROD_W:0]     pc_round;
  logic [PROD_W:0]     ps_round;
  logic [OFF_W-1:0]    co_pos;
  logic [OFF_W-1:0]    si_pos;
  logic [OFF_W-1:0]    co_neg;
  logic [OFF_W-1:0]    si_neg;
  logic [OFF_W-1:0]    dx_next;
  logic [OFF_W-1:0]    dy_next;

  always_comb begin
    pc_round = {1'b0, s2_pc} + ROUND_HALF;
    ps_round = {1'b0, s2_ps} + ROUND_HALF;
    co_pos   = {1'b0, pc_round[TRIG_FRAC_BITS +: RADIUS_W]};
    si_pos   = {1'b0, ps_round[TRIG_FRAC_BITS +: RADIUS_W]};
    co_neg   = OFF_W'(0) - co_pos;
    si_neg   = OFF_W'(0) - si_pos;
    case (s2_corner)
      CORNER_TL: begin
        dx_next = co_neg;
        dy_next = si_neg;
      end
      CORNER_TR: begin
        dx_next = si_pos;
        dy_next = co_neg;
      end
      CORNER_BR: begin
        dx_next = co_pos;
        dy_next = si_pos;
      end
      default: begin
        dx_next = si_neg;
        dy_next = co_pos;
      end
    endcase
  end

  // stage 4: vertex = center + offset, output register
  corner_t             s4_corner;
  logic                s4_last;
  logic [VERT_W-1:0]   s4_x;
  logic [VERT_W-1:0]   s4_y;

  logic [CTR_W-1:0]    sum_x;
  logic [CTR_W-1:0]    sum_y;

  assign sum_x = s3_cx + {{(CTR_W - OFF_W){s3_dx[OFF_W-1]}}, s3_dx};
  assign sum_y = s3_cy + {{(CTR_W - OFF_W){s3_dy[OFF_W-1]}}, s3_dy};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_corner <= gen_corner;
      s1_last   <= step_last && (gen_corner == CORNER_BL);
      s1_rad    <= rad_sel;
      s1_cos    <= TRIG_TAB[{seg_eff, gen_step}];
      s1_sin    <= TRIG_TAB[{seg_eff, seg_eff - gen_step}];
      s1_cx     <= cx_next;
      s1_cy     <= cy_next;

      s2_corner <= s1_corner;
      s2_last   <= s1_last;
      s2_pc     <= PROD_W'(s1_rad) * PROD_W'(s1_cos);
      s2_ps     <= PROD_W'(s1_rad) * PROD_W'(s1_sin);
      s2_cx     <= s1_cx;
      s2_cy     <= s1_cy;

      s3_corner <= s2_corner;
      s3_last   <= s2_last;
      s3_dx     <= dx_next;
      s3_dy     <= dy_next;
      s3_cx     <= s2_cx;
      s3_cy     <= s2_cy;

      s4_corner <= s3_corner;
      s4_last   <= s3_last;
      s4_x      <= sum_x[VERT_W-1:0];
      s4_y      <= sum_y[VERT_W-1:0];
    end
  end

  assign vert.valid        = s4_valid;
  assign vert.vert_x       = s4_x;
  assign vert.vert_y       = s4_y;
  assign vert.corner_index = s4_corner;
  assign vert.last_vertex  = s4_last;

endmodule

@@ src/rrot_checker.sv @@
// port-level checks for the outline tessellator, bound to the top level
module rrot_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rect_valid,
  input logic                       rect_ready,
  input logic                       vert_valid,
  input logic                       vert_ready,
  input logic [rrot_pkg::VERT_W-1:0] vert_x,
  input logic [rrot_pkg::VERT_W-1:0] vert_y,
  input logic [1:0]                 corner_index,
  input logic                       last_vertex
);
  import rrot_pkg::*;

  // a stalled vertex holds
  a_vert_hold: assert property (@(posedge clk) disable iff (rst)
    vert_valid && !vert_ready |=>
      vert_valid && $stable(vert_x) && $stable(vert_y) &&
      $stable(corner_index) && $stable(last_vertex))
    else $error("stalled vertex changed");

  // one rectangle at a time
  a_rect_busy: assert property (@(posedge clk) disable iff (rst)
    rect_valid && rect_ready |=> !rect_ready)
    else $error("rectangle taken while previous still issuing");

  // the outline closes on the bottom-left corner
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    vert_valid && last_vertex |-> corner_index == CORNER_BL)
    else $error("last vertex not on bottom-left corner");

  // corners never step back inside one outline
  a_corner_order: assert property (@(posedge clk) disable iff (rst)
    vert_valid && vert_ready && !last_vertex |=>
      !vert_valid || corner_index >= $past(corner_index))
    else $error("corner order broken within an outline");

endmodule

bind rounded_rect_outline_tessellator_core rrot_checker u_rrot_checker (
  .clk          (clk),
  .rst          (rst),
  .rect_valid   (rect.valid),
  .rect_ready   (rect.ready),
  .vert_valid   (vert.valid),
  .vert_ready   (vert.ready),
  .vert_x       (vert.vert_x),
  .vert_y       (vert.vert_y),
  .corner_index (vert.corner_index),
  .last_vertex  (vert.last_vertex)
);
